// ===== design/rcr_pkg.sv =====
package rcr_pkg;

  localparam int COORD_W = 26;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t ONE_UNIT = 26'sd256;

  typedef enum logic [1:0] {
    FN_CLEAR   = 2'd0,
    FN_FILL    = 2'd1,
    FN_OUTLINE = 2'd2,
    FN_READ    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_SIZE  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_BG     = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RWAIT,
    ST_FIN
  } state_t;

  typedef struct packed {
    coord_t x_lo;
    coord_t x_hi;
    coord_t x_in_lo;
    coord_t x_in_hi;
    coord_t y_lo;
    coord_t y_hi;
    coord_t y_in_lo;
    coord_t y_in_hi;
  } bounds_t;

endpackage

// ===== design/rcr_ram.sv =====
module rcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/rcr_cell_test.sv =====
module rcr_cell_test #(
  parameter int IDX_W = 8
) (
  input  logic [IDX_W-1:0]  col,
  input  logic [IDX_W-1:0]  row,
  input  rcr_pkg::bounds_t  bnd,
  input  logic              outline,
  output logic              hit
);

  rcr_pkg::coord_t px;
  rcr_pkg::coord_t py;
  logic            in_box;
  logic            on_rim;

  assign px = rcr_pkg::coord_t'({col, 8'h00});
  assign py = rcr_pkg::coord_t'({row, 8'h00});

  assign in_box = (px >= bnd.x_lo) && (px <= bnd.x_hi) &&
                  (py >= bnd.y_lo) && (py <= bnd.y_hi);
  assign on_rim = (px < bnd.x_in_lo) || (py < bnd.y_in_lo) ||
                  (px > bnd.x_in_hi) || (py > bnd.y_in_hi);
  assign hit    = in_box && (!outline || on_rim);

endmodule

// ===== design/rectangle_canvas_rasterizer.sv =====
// Character canvas rasterizer: one command word in, one result word out. A clear or
// draw command sweeps the rows*cols cells in use one cell per cycle through the single
// canvas write port; a read waits in ST_RWAIT for the registered memory read, and a
// rejected shape or a command on an empty canvas goes straight to ST_FIN. The input is
// not ready while a command is in progress. The canvas memory comes up undefined and
// holds no clearing pass: issue a clear before reading cells that no draw has covered.
module rectangle_canvas_rasterizer #(
  parameter int MAX_SIDE = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic signed [23:0] in_rect_x,
  input  logic signed [23:0] in_rect_y,
  input  logic signed [23:0] in_rect_width,
  input  logic signed [23:0] in_rect_height,
  input  logic [7:0]         in_paint_char,
  input  logic [7:0]         in_read_col,
  input  logic [7:0]         in_read_row,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_cell_value,
  output logic [1:0]         out_status,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data
);

  localparam int IDX_W  = $clog2(MAX_SIDE);
  localparam int CNT_W  = $clog2(MAX_SIDE + 1);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = 1 << ADDR_W;

  rcr_pkg::state_t  state_r, state_nxt;
  rcr_pkg::func_t   func_in;
  rcr_pkg::func_t   func_r, func_nxt;
  rcr_pkg::bounds_t bnd_r, bnd_nxt;
  rcr_pkg::status_t res_status_r, res_status_nxt;
  logic [7:0]       res_value_r, res_value_nxt;
  logic [7:0]       paint_r, paint_nxt;
  logic [IDX_W-1:0] col_r, col_nxt;
  logic [IDX_W-1:0] row_r, row_nxt;
  logic             out_valid_r;
  logic [7:0]       out_cell_value_r;
  logic [1:0]       out_status_r;
  logic [8:0]       cfg_width_r;
  logic [8:0]       cfg_height_r;
  logic [7:0]       cfg_bg_r;

  logic [CNT_W-1:0] cols;
  logic [CNT_W-1:0] rows;
  logic             empty;
  logic             bad_size;
  logic             read_oob;
  logic             last_col;
  logic             last_row;
  logic             hit;
  logic             accept;
  logic             out_load;
  logic             ram_we;
  logic [7:0]       ram_wdata;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]       ram_rdata;

  rcr_pkg::coord_t  x_ext, y_ext, w_ext, h_ext;

  assign func_in = rcr_pkg::func_t'(in_func);
  assign x_ext   = rcr_pkg::COORD_W'(in_rect_x);
  assign y_ext   = rcr_pkg::COORD_W'(in_rect_y);
  assign w_ext   = rcr_pkg::COORD_W'(in_rect_width);
  assign h_ext   = rcr_pkg::COORD_W'(in_rect_height);

  assign cols = (32'(cfg_width_r) > MAX_SIDE) ? CNT_W'(MAX_SIDE) : CNT_W'(cfg_width_r);
  assign rows = (32'(cfg_height_r) > MAX_SIDE) ? CNT_W'(MAX_SIDE) : CNT_W'(cfg_height_r);
  assign empty    = (cols == '0) || (rows == '0);
  assign bad_size = in_rect_width[23] || (in_rect_width == '0) ||
                    in_rect_height[23] || (in_rect_height == '0);
  assign read_oob = (32'(in_read_col) >= 32'(cols)) || (32'(in_read_row) >= 32'(rows));
  assign last_col = (col_r == IDX_W'(cols - CNT_W'(1)));
  assign last_row = (row_r == IDX_W'(rows - CNT_W'(1)));

  assign accept   = in_valid && in_ready;

  rcr_cell_test #(
    .IDX_W(IDX_W)
  ) u_test (
    .col     (col_r),
    .row     (row_r),
    .bnd     (bnd_r),
    .outline (func_r == rcr_pkg::FN_OUTLINE),
    .hit     (hit)
  );

  assign ram_waddr = {row_r, col_r};
  assign ram_raddr = {IDX_W'(in_read_row), IDX_W'(in_read_col)};
  assign ram_wdata = (func_r == rcr_pkg::FN_CLEAR) ? cfg_bg_r : paint_r;

  rcr_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_canvas (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rcr_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (func_in)
            rcr_pkg::FN_CLEAR: begin
              state_nxt = empty ? rcr_pkg::ST_FIN : rcr_pkg::ST_SCAN;
            end
            rcr_pkg::FN_FILL, rcr_pkg::FN_OUTLINE: begin
              state_nxt = (bad_size || empty) ? rcr_pkg::ST_FIN : rcr_pkg::ST_SCAN;
            end
            rcr_pkg::FN_READ: begin
              state_nxt = read_oob ? rcr_pkg::ST_FIN : rcr_pkg::ST_RWAIT;
            end
            default: state_nxt = rcr_pkg::ST_FIN;
          endcase
        end
      end
      rcr_pkg::ST_SCAN: begin
        if (last_col && last_row) begin
          state_nxt = rcr_pkg::ST_FIN;
        end
      end
      rcr_pkg::ST_RWAIT: state_nxt = rcr_pkg::ST_FIN;
      rcr_pkg::ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = rcr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rcr_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = (state_r == rcr_pkg::ST_IDLE);
    ram_we   = (state_r == rcr_pkg::ST_SCAN) && ((func_r == rcr_pkg::FN_CLEAR) || hit);
    out_load = (state_r == rcr_pkg::ST_FIN) && (!out_valid_r || out_ready);
  end

  // datapath
  always_comb begin
    func_nxt       = func_r;
    bnd_nxt        = bnd_r;
    paint_nxt      = paint_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    if (accept) begin
      func_nxt        = func_in;
      paint_nxt       = in_paint_char;
      col_nxt         = '0;
      row_nxt         = '0;
      res_value_nxt   = '0;
      bnd_nxt.x_lo    = x_ext;
      bnd_nxt.x_hi    = x_ext + w_ext;
      bnd_nxt.x_in_lo = x_ext + rcr_pkg::ONE_UNIT;
      bnd_nxt.x_in_hi = x_ext + w_ext - rcr_pkg::ONE_UNIT;
      bnd_nxt.y_lo    = y_ext;
      bnd_nxt.y_hi    = y_ext + h_ext;
      bnd_nxt.y_in_lo = y_ext + rcr_pkg::ONE_UNIT;
      bnd_nxt.y_in_hi = y_ext + h_ext - rcr_pkg::ONE_UNIT;
      res_status_nxt  = rcr_pkg::STAT_OK;
      if ((func_in == rcr_pkg::FN_FILL || func_in == rcr_pkg::FN_OUTLINE) && bad_size) begin
        res_status_nxt = rcr_pkg::STAT_SIZE;
      end else if (func_in == rcr_pkg::FN_READ && read_oob) begin
        res_status_nxt = rcr_pkg::STAT_RANGE;
      end
    end else if (state_r == rcr_pkg::ST_SCAN) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = row_r + IDX_W'(1);
      end else begin
        col_nxt = col_r + IDX_W'(1);
      end
    end else if (state_r == rcr_pkg::ST_RWAIT) begin
      res_value_nxt = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rcr_pkg::ST_IDLE;
      out_valid_r  <= 1'b0;
      cfg_width_r  <= 9'd256;
      cfg_height_r <= 9'd256;
      cfg_bg_r     <= 8'd32;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (rcr_pkg::reg_idx_t'(cfg_index))
          rcr_pkg::REG_WIDTH:  cfg_width_r  <= cfg_data;
          rcr_pkg::REG_HEIGHT: cfg_height_r <= cfg_data;
          rcr_pkg::REG_BG:     cfg_bg_r     <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    bnd_r        <= bnd_nxt;
    paint_r      <= paint_nxt;
    col_r        <= col_nxt;
    row_r        <= row_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    if (out_load) begin
      out_cell_value_r <= res_value_r;
      out_status_r     <= res_status_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_value = out_cell_value_r;
  assign out_status     = out_status_r;

endmodule

// ===== design/rcr_checker.sv =====
module rcr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_cell_value,
  input logic [1:0] out_status
);

  // held result word stays put
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cell_value) && $stable(out_status))
    else $error("result word changed while stalled");

  // error results carry no character
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != rcr_pkg::STAT_OK |-> out_cell_value == 8'd0)
    else $error("nonzero value on error result");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

  // busy right after taking a command word
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

endmodule

bind rectangle_canvas_rasterizer rcr_checker u_rcr_checker (.*);
